/* rtl/sccdt_pkg.sv */
// Shared types, codes and helpers of the serial controlled countdown timer.
`default_nettype none

package sccdt_pkg;

  // Register reset values
  localparam logic [7:0] SYNC_BYTE_RST    = 8'd170;
  localparam logic [4:0] FULL_RELOAD_RST  = 5'd24;
  localparam logic [4:0] SHORT_RELOAD_RST = 5'd13;

  // Configuration address width: registers at byte addresses 0, 4, 8
  localparam int unsigned CFG_AW = 4;

  // Register indexes
  typedef enum logic [1:0] {
    REG_SYNC_BYTE    = 2'd0,
    REG_FULL_RELOAD  = 2'd1,
    REG_SHORT_RELOAD = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  // Frame commands
  localparam logic [7:0] CMD_TOGGLE = 8'd222;
  localparam logic [7:0] CMD_PAUSE  = 8'd223;
  localparam logic [7:0] CMD_FULL   = 8'd224;
  localparam logic [7:0] CMD_SHORT  = 8'd225;

  localparam logic [7:0] CHK_MASK = 8'h0F;

  // Input word kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Position inside a four-byte frame
  typedef enum logic [1:0] {
    FP_START = 2'd0,
    FP_CMD   = 2'd1,
    FP_DATA  = 2'd2,
    FP_CHECK = 2'd3
  } frame_pos_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] tens_digit;
    logic [3:0] ones_digit;
    logic       is_paused;
    logic       expired;
    logic       frame_accepted;
    logic       checksum_error;
  } out_word_t;

  // Tens digit of a count up to 31
  function automatic logic [1:0] tens_of(input logic [4:0] sec);
    logic [1:0] t;
    if (sec >= 5'd30) begin
      t = 2'd3;
    end else if (sec >= 5'd20) begin
      t = 2'd2;
    end else if (sec >= 5'd10) begin
      t = 2'd1;
    end else begin
      t = 2'd0;
    end
    return t;
  endfunction

  // Ones digit: subtract the tens already found
  function automatic logic [3:0] ones_of(input logic [4:0] sec);
    logic [4:0] base;
    logic [4:0] diff;
    case (tens_of(sec))
      2'd3:    base = 5'd30;
      2'd2:    base = 5'd20;
      2'd1:    base = 5'd10;
      default: base = 5'd0;
    endcase
    diff = sec - base;
    return diff[3:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/serial_controlled_countdown_timer.sv */
// Serial controlled countdown timer: frame decoder, second counter and result register.
// The result word of an input word is registered at the edge that accepts it.
// Throughput: one word per cycle unless the sink stalls; a new word is taken while the
// result register drains. The frame decoder and counter update in the same cycle.
// Reset (rst_n low, synchronous): count = 24, running, frame decoder waits for a start byte,
// registers return to 170 / 24 / 13 and the result register empties.
`default_nettype none

module serial_controlled_countdown_timer (
  input  wire                              clk,
  input  wire                              rst_n,
  // input channel
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  sccdt_pkg::in_word_t        in_data,
  // result channel
  output logic                             out_valid,
  input  wire                              out_ready,
  output sccdt_pkg::out_word_t             out_data,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [sccdt_pkg::CFG_AW-1:0]     paddr,
  input  wire  [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import sccdt_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] sync_byte_r;
  logic [4:0] full_reload_r;
  logic [4:0] short_reload_r;
  reg_idx_t   cfg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r    <= SYNC_BYTE_RST;
      full_reload_r  <= FULL_RELOAD_RST;
      short_reload_r <= SHORT_RELOAD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SYNC_BYTE:    sync_byte_r    <= pwdata[7:0];
        REG_FULL_RELOAD:  full_reload_r  <= pwdata[4:0];
        REG_SHORT_RELOAD: short_reload_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    unique case (cfg_idx)
      REG_SYNC_BYTE:    prdata = {24'd0, sync_byte_r};
      REG_FULL_RELOAD:  prdata = {27'd0, full_reload_r};
      REG_SHORT_RELOAD: prdata = {27'd0, short_reload_r};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: take a word whenever the result register is empty or draining
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Timer and frame state
  // ---------------------------------------------------------------------------
  frame_pos_t fpos_r, fpos_nxt;
  logic [4:0] seconds_r, seconds_nxt;
  logic       paused_r, paused_nxt;
  logic [7:0] chk_r, chk_nxt;
  logic [7:0] cmd_r, cmd_nxt;

  logic       is_byte;
  logic       is_tick;
  logic       chk_ok;

  assign is_byte = in_fire && (in_data.command == KIND_BYTE);
  assign is_tick = in_fire && (in_data.command == KIND_TICK);
  assign chk_ok  = (in_data.rx_byte == chk_r);

  // Frame position: advance on each byte once a start byte is seen
  always_comb begin
    fpos_nxt = fpos_r;
    if (is_byte) begin
      unique case (fpos_r)
        FP_START: if (in_data.rx_byte == sync_byte_r) fpos_nxt = FP_CMD;
        FP_CMD:   fpos_nxt = FP_DATA;
        FP_DATA:  fpos_nxt = FP_CHECK;
        FP_CHECK: fpos_nxt = FP_START;
        default:  fpos_nxt = FP_START;
      endcase
    end
  end

  // Datapath and result flags
  logic expired_nxt;
  logic accepted_nxt;
  logic cerr_nxt;

  always_comb begin
    seconds_nxt  = seconds_r;
    paused_nxt   = paused_r;
    chk_nxt      = chk_r;
    cmd_nxt      = cmd_r;
    expired_nxt  = 1'b0;
    accepted_nxt = 1'b0;
    cerr_nxt     = 1'b0;

    if (is_tick && !paused_r) begin
      if (seconds_r == 5'd0) begin
        // ran past zero: reload, halt and flag
        seconds_nxt = full_reload_r;
        paused_nxt  = 1'b1;
        expired_nxt = 1'b1;
      end else begin
        seconds_nxt = seconds_r - 5'd1;
      end
    end

    if (is_byte) begin
      unique case (fpos_r)
        FP_START: if (in_data.rx_byte == sync_byte_r) chk_nxt = 8'd0;
        FP_CMD: begin
          cmd_nxt = in_data.rx_byte;
          chk_nxt = in_data.rx_byte & CHK_MASK;
        end
        FP_DATA:  chk_nxt = chk_r ^ in_data.rx_byte;
        FP_CHECK: begin
          if (chk_ok) begin
            accepted_nxt = 1'b1;
            // run the latched command; unknown codes only end the frame
            case (cmd_r)
              CMD_TOGGLE: paused_nxt = !paused_r;
              CMD_PAUSE:  paused_nxt = 1'b1;
              CMD_FULL: begin
                seconds_nxt = full_reload_r;
                paused_nxt  = 1'b0;
              end
              CMD_SHORT: begin
                seconds_nxt = short_reload_r;
                paused_nxt  = 1'b0;
              end
              default: ;
            endcase
          end else begin
            cerr_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpos_r    <= FP_START;
      seconds_r <= FULL_RELOAD_RST;
      paused_r  <= 1'b0;
      chk_r     <= 8'd0;
      cmd_r     <= 8'd0;
    end else begin
      fpos_r    <= fpos_nxt;
      seconds_r <= seconds_nxt;
      paused_r  <= paused_nxt;
      chk_r     <= chk_nxt;
      cmd_r     <= cmd_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on accept, hold while the sink stalls, drop on take
  // ---------------------------------------------------------------------------
  out_word_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r.tens_digit     <= tens_of(seconds_nxt);
      out_r.ones_digit     <= ones_of(seconds_nxt);
      out_r.is_paused      <= paused_nxt;
      out_r.expired        <= expired_nxt;
      out_r.frame_accepted <= accepted_nxt;
      out_r.checksum_error <= cerr_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word left no result");

  a_expire_pauses: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.expired) |-> (out_r.is_paused && !out_r.frame_accepted
                                        && !out_r.checksum_error))
    else $error("expiry result inconsistent");

  a_frame_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.frame_accepted && out_r.checksum_error))
    else $error("frame both accepted and rejected");

  a_ones_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.ones_digit <= 4'd9))
    else $error("ones digit out of range");

endmodule

`default_nettype wire
